/* rtl/rpt_pkg.sv */
// rpt_pkg: beat types, register codes, widths and the radix-16 divide step
// for the ray plane transfer unit. No dependencies.
package rpt_pkg;

	localparam int PW = 37;
	localparam int NW = 56;
	localparam int DW = 17;
	localparam int DIV_BITS = 4;
	localparam int DIV_STAGES = NW / DIV_BITS;
	localparam int AW = 6;

	localparam logic [2:0] REG_ROT0 = 3'd0;
	localparam logic [2:0] REG_ROT1 = 3'd1;
	localparam logic [2:0] REG_ROT2 = 3'd2;
	localparam logic [2:0] REG_SHXY = 3'd3;
	localparam logic [2:0] REG_SHZ = 3'd4;

	localparam logic [47:0] ROT0_RST = 48'h0000_0000_4000;
	localparam logic [47:0] ROT1_RST = 48'h0000_4000_0000;
	localparam logic [47:0] ROT2_RST = 48'h4000_0000_0000;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] dir_l;
		logic signed [15:0] dir_m;
		logic signed [15:0] dir_n;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [15:0] out_l;
		logic signed [15:0] out_m;
		logic signed [15:0] out_n;
		logic               parallel;
		logic               overflow;
	} out_beat_t;

	typedef struct packed {
		logic [DW-1:0]       rem;
		logic [DIV_BITS-1:0] qbits;
	} div_step_t;

	// restoring division, four quotient bits, MSB first
	function automatic div_step_t div_step(input logic [DW-1:0] rem_in,
			input logic [DIV_BITS-1:0] nib, input logic [DW-1:0] den);
		logic [DW:0] r;
		div_step_t   res;
		r = '0;
		res.rem = rem_in;
		res.qbits = '0;
		for (int k = DIV_BITS - 1; k >= 0; k--) begin
			r = {res.rem, nib[k]};
			if (r >= {1'b0, den}) begin
				r = r - {1'b0, den};
				res.qbits[k] = 1'b1;
			end
			res.rem = r[DW-1:0];
		end
		return res;
	endfunction

endpackage

/* rtl/rpt_div.sv */
// rpt_div: two-lane pipelined unsigned divider sharing one divisor,
// four quotient bits per stage. Depends on rpt_pkg.
module rpt_div import rpt_pkg::*; (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num_a,
	input  logic [NW-1:0] num_b,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo_a,
	output logic [NW-1:0] quo_b
);

	logic [NW-1:0] na_s [DIV_STAGES];
	logic [NW-1:0] nb_s [DIV_STAGES];
	logic [NW-1:0] qa_s [DIV_STAGES];
	logic [NW-1:0] qb_s [DIV_STAGES];
	logic [DW-1:0] ra_s [DIV_STAGES];
	logic [DW-1:0] rb_s [DIV_STAGES];
	logic [DW-1:0] d_s  [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [NW-1:0] na_in, nb_in, qa_in, qb_in;
		logic [DW-1:0] ra_in, rb_in, d_in;
		div_step_t     sa, sb;

		if (k == 0) begin : g_first
			assign na_in = num_a;
			assign nb_in = num_b;
			assign qa_in = '0;
			assign qb_in = '0;
			assign ra_in = '0;
			assign rb_in = '0;
			assign d_in  = den;
		end else begin : g_next
			assign na_in = na_s[k-1];
			assign nb_in = nb_s[k-1];
			assign qa_in = qa_s[k-1];
			assign qb_in = qb_s[k-1];
			assign ra_in = ra_s[k-1];
			assign rb_in = rb_s[k-1];
			assign d_in  = d_s[k-1];
		end

		assign sa = div_step(ra_in, na_in[NW-1 -: DIV_BITS], d_in);
		assign sb = div_step(rb_in, nb_in[NW-1 -: DIV_BITS], d_in);

		always_ff @(posedge clk) begin
			if (en) begin
				na_s[k] <= {na_in[NW-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
				nb_s[k] <= {nb_in[NW-DIV_BITS-1:0], {DIV_BITS{1'b0}}};
				qa_s[k] <= {qa_in[NW-DIV_BITS-1:0], sa.qbits};
				qb_s[k] <= {qb_in[NW-DIV_BITS-1:0], sb.qbits};
				ra_s[k] <= sa.rem;
				rb_s[k] <= sb.rem;
				d_s[k]  <= d_in;
			end
		end
	end

	assign quo_a = qa_s[DIV_STAGES-1];
	assign quo_b = qb_s[DIV_STAGES-1];

endmodule

/* rtl/ray_plane_transfer_unit.sv */
// ray_plane_transfer_unit: rotate a ray, shift it and carry it to the local
// z=0 plane. Depends on rpt_pkg and rpt_div.
//
//  channel | signals                          | beat taken when
//  in      | in_valid, in_stall, in_data      | in_valid & !in_stall
//  out     | out_valid, out_stall, out_data   | out_valid & !out_stall
//  cfg     | psel, penable, pwrite, paddr ... | psel & penable & pwrite
//
// One ray per cycle unless a stall on out holds it; four arithmetic stages, 14 divider
// stages of four quotient bits, one output register.
// Reset clears valid bits and loads the identity matrix and zero shift.
// A stall on out while out is full holds every stage and raises in_stall.
module ray_plane_transfer_unit import rpt_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  in_beat_t        in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output out_beat_t       out_data,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [AW-1:0]   paddr,
	input  logic [63:0]     pwdata,
	output logic [63:0]     prdata,
	output logic            pready
);

	typedef struct packed {
		logic signed [PW-1:0] p2x;
		logic signed [PW-1:0] p2y;
		logic signed [15:0]   dl;
		logic signed [15:0]   dm;
		logic signed [15:0]   dn;
		logic signed [31:0]   px;
		logic signed [31:0]   py;
		logic signed [31:0]   pz;
		logic                 par;
		logic                 ovd;
		logic                 negx;
		logic                 negy;
	} side_t;

	logic [47:0] rot0_q, rot1_q, rot2_q;
	logic [63:0] shxy_q;
	logic [31:0] shz_q;
	logic        wr;
	logic        adv;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot0_q <= ROT0_RST;
			rot1_q <= ROT1_RST;
			rot2_q <= ROT2_RST;
			shxy_q <= '0;
			shz_q  <= '0;
		end else if (wr) begin
			unique case (paddr[5:3])
				REG_ROT0: rot0_q <= pwdata[47:0];
				REG_ROT1: rot1_q <= pwdata[47:0];
				REG_ROT2: rot2_q <= pwdata[47:0];
				REG_SHXY: shxy_q <= pwdata;
				REG_SHZ:  shz_q  <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			REG_ROT0: prdata = {16'd0, rot0_q};
			REG_ROT1: prdata = {16'd0, rot1_q};
			REG_ROT2: prdata = {16'd0, rot2_q};
			REG_SHXY: prdata = shxy_q;
			REG_SHZ:  prdata = {32'd0, shz_q};
			default:  prdata = '0;
		endcase
	end

	logic out_valid_q;
	assign adv = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	logic signed [15:0] m [3][3];
	assign m[0][0] = rot0_q[15:0];
	assign m[0][1] = rot0_q[31:16];
	assign m[0][2] = rot0_q[47:32];
	assign m[1][0] = rot1_q[15:0];
	assign m[1][1] = rot1_q[31:16];
	assign m[1][2] = rot1_q[47:32];
	assign m[2][0] = rot2_q[15:0];
	assign m[2][1] = rot2_q[31:16];
	assign m[2][2] = rot2_q[47:32];

	logic signed [15:0] vin [3];
	logic signed [31:0] pin [3];
	assign vin[0] = in_data.dir_l;
	assign vin[1] = in_data.dir_m;
	assign vin[2] = in_data.dir_n;
	assign pin[0] = in_data.pos_x;
	assign pin[1] = in_data.pos_y;
	assign pin[2] = in_data.pos_z;

	// s1: products
	logic               v_s1;
	logic signed [31:0] dp_s1 [3][3];
	logic signed [47:0] pp_s1 [3][3];
	logic signed [31:0] pos_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pos_s1[i] <= pin[i];
				for (int j = 0; j < 3; j++) begin
					dp_s1[i][j] <= m[i][j] * vin[j];
					pp_s1[i][j] <= m[i][j] * pin[j];
				end
			end
		end
	end

	// s2: sums, rounding, saturation, shift
	logic signed [33:0] dsum [3];
	logic signed [49:0] psum [3];
	logic signed [19:0] drnd [3];
	logic signed [35:0] prnd [3];
	logic signed [15:0] dsat [3];
	logic [2:0]         dov;
	logic signed [31:0] sh [3];

	assign sh[0] = shxy_q[31:0];
	assign sh[1] = shxy_q[63:32];
	assign sh[2] = shz_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dsum[i] = 34'(dp_s1[i][0]) + 34'(dp_s1[i][1]) + 34'(dp_s1[i][2])
				+ 34'sd8192;
			drnd[i] = dsum[i][33:14];
			psum[i] = 50'(pp_s1[i][0]) + 50'(pp_s1[i][1]) + 50'(pp_s1[i][2])
				+ 50'sd8192;
			prnd[i] = psum[i][49:14];
			dov[i] = 1'b0;
			if (drnd[i] > 20'sd32767) begin
				dsat[i] = 16'sh7fff;
				dov[i] = 1'b1;
			end else if (drnd[i] < -20'sd32768) begin
				dsat[i] = -16'sh8000;
				dov[i] = 1'b1;
			end else begin
				dsat[i] = drnd[i][15:0];
			end
		end
	end

	logic                 v_s2;
	logic signed [15:0]   d2_s2 [3];
	logic signed [PW-1:0] p2_s2 [3];
	logic signed [31:0]   pos_s2 [3];
	logic                 ovd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d2_s2[i]  <= dsat[i];
				p2_s2[i]  <= PW'(prnd[i]) - PW'(sh[i]);
				pos_s2[i] <= pos_s1[i];
			end
			ovd_s2 <= |dov;
		end
	end

	// s3: plane step numerators
	logic                 v_s3;
	logic signed [52:0]   nx_s3, ny_s3;
	side_t                sd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s3 <= p2_s2[2] * d2_s2[0];
			ny_s3 <= p2_s2[2] * d2_s2[1];
			sd_s3.p2x  <= p2_s2[0];
			sd_s3.p2y  <= p2_s2[1];
			sd_s3.dl   <= d2_s2[0];
			sd_s3.dm   <= d2_s2[1];
			sd_s3.dn   <= d2_s2[2];
			sd_s3.px   <= pos_s2[0];
			sd_s3.py   <= pos_s2[1];
			sd_s3.pz   <= pos_s2[2];
			sd_s3.par  <= (d2_s2[2] == 16'sd0);
			sd_s3.ovd  <= ovd_s2;
			sd_s3.negx <= 1'b0;
			sd_s3.negy <= 1'b0;
		end
	end

	// s4: magnitudes, rounding bias, signs
	logic          v_s4;
	logic [NW-1:0] na_s4, nb_s4;
	logic [DW-1:0] den_s4;
	side_t         sd_s4;
	logic [52:0]   anx, any;
	logic [15:0]   adn;
	side_t         side4;

	always_comb begin
		anx = nx_s3[52] ? 53'(-nx_s3) : nx_s3;
		any = ny_s3[52] ? 53'(-ny_s3) : ny_s3;
		adn = sd_s3.dn[15] ? 16'(-sd_s3.dn) : sd_s3.dn;
		side4 = sd_s3;
		side4.negx = nx_s3[52] ^ sd_s3.dn[15];
		side4.negy = ny_s3[52] ^ sd_s3.dn[15];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			na_s4  <= {2'b0, anx, 1'b0} + NW'(adn);
			nb_s4  <= {2'b0, any, 1'b0} + NW'(adn);
			den_s4 <= {adn, 1'b0};
			sd_s4  <= side4;
		end
	end

	// divider with side line alongside
	logic [NW-1:0] qx, qy;

	rpt_div u_div (
		.clk   (clk),
		.en    (adv),
		.num_a (na_s4),
		.num_b (nb_s4),
		.den   (den_s4),
		.quo_a (qx),
		.quo_b (qy)
	);

	logic  sd_v [DIV_STAGES];
	side_t sd_q [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) sd_v[k] <= 1'b0;
		end else if (adv) begin
			sd_v[0] <= v_s4;
			for (int k = 1; k < DIV_STAGES; k++) sd_v[k] <= sd_v[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_q[0] <= sd_s4;
			for (int k = 1; k < DIV_STAGES; k++) sd_q[k] <= sd_q[k-1];
		end
	end

	// finish: apply quotient, saturate, select
	function automatic logic [32:0] sat32(input logic signed [NW+1:0] v);
		logic [32:0] r;
		if (v > (NW+2)'(64'sh7fff_ffff)) r = {1'b1, 32'h7fff_ffff};
		else if (v < -(NW+2)'(64'sh8000_0000)) r = {1'b1, 32'h8000_0000};
		else r = {1'b0, v[31:0]};
		return r;
	endfunction

	side_t              sf;
	logic signed [NW+1:0] sqx, sqy, dx, dy;
	logic [32:0]        rx, ry;
	out_beat_t          res;

	always_comb begin
		sf  = sd_q[DIV_STAGES-1];
		sqx = sf.negx ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
		sqy = sf.negy ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
		dx  = (NW+2)'(sf.p2x) - sqx;
		dy  = (NW+2)'(sf.p2y) - sqy;
		rx  = sat32(dx);
		ry  = sat32(dy);
		res.out_l = sf.dl;
		res.out_m = sf.dm;
		res.out_n = sf.dn;
		res.parallel = sf.par;
		if (sf.par) begin
			res.out_x = sf.px;
			res.out_y = sf.py;
			res.out_z = sf.pz;
			res.overflow = sf.ovd;
		end else begin
			res.out_x = rx[31:0];
			res.out_y = ry[31:0];
			res.out_z = '0;
			res.overflow = sf.ovd | rx[32] | ry[32];
		end
	end

	out_beat_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= sd_v[DIV_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (adv) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/rpt_checker.sv */
// rpt_checker: port-level checks on the ray plane transfer unit, bound to
// the top level. Depends on rpt_pkg.
module rpt_checker import rpt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_beat_t out_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled out beat changed");

	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in stalled while out free");

	a_par: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.parallel == (out_data.out_n == 16'sd0)))
		else $error("parallel flag disagrees with direction");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.parallel |-> out_data.out_z == 32'sd0)
		else $error("plane point off z=0");

endmodule

bind ray_plane_transfer_unit rpt_checker u_rpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

/* dv/tb_ray_plane_transfer_unit.sv */
// tb_ray_plane_transfer_unit: self-checking bench for ray_plane_transfer_unit.
// Drives directed and random rays, predicts each result in fixed point and
// compares every out beat. Depends on rpt_pkg and the unit RTL.
module tb_ray_plane_transfer_unit;
	import rpt_pkg::*;

	localparam int LATENCY = 19;
	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [AW-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	ray_plane_transfer_unit dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [47:0] rot [3];
	logic [63:0] shift_xy_q;
	logic [31:0] shift_z_q;

	out_beat_t ray_q[$];
	int errors = 0;
	int cycles = 0;
	int send_idle = 31;
	int recv_idle = 69;
	bit hold_go = 1'b0;
	bit hold_on = 1'b0;

	function automatic longint rnd14(longint v);
		return (v + 64'sd8192) >>> 14;
	endfunction

	function automatic longint clamp(longint v, int w, ref bit ov);
		longint hi, lo;
		hi = (64'sd1 <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			ov = 1'b1;
			return hi;
		end
		if (v < lo) begin
			ov = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic longint div_near(longint num, longint den);
		bit neg;
		longint an, ad, q;
		neg = (num < 0) != (den < 0);
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		q = (2 * an + ad) / (2 * ad);
		return neg ? -q : q;
	endfunction

	function automatic out_beat_t transfer_ray(in_beat_t r);
		out_beat_t o;
		longint p[3], v[3], d[3], p2[3], sh[3], acc, e;
		bit ov;
		ov = 1'b0;
		p[0] = longint'(r.pos_x); p[1] = longint'(r.pos_y); p[2] = longint'(r.pos_z);
		v[0] = longint'(r.dir_l); v[1] = longint'(r.dir_m); v[2] = longint'(r.dir_n);
		sh[0] = longint'($signed(shift_xy_q[31:0]));
		sh[1] = longint'($signed(shift_xy_q[63:32]));
		sh[2] = longint'($signed(shift_z_q));
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) begin
				e = longint'($signed(rot[i][16*j +: 16]));
				acc += e * v[j];
			end
			d[i] = clamp(rnd14(acc), 16, ov);
		end
		o.out_l = d[0][15:0];
		o.out_m = d[1][15:0];
		o.out_n = d[2][15:0];
		o.parallel = (d[2] == 0);
		if (o.parallel) begin
			o.out_x = r.pos_x;
			o.out_y = r.pos_y;
			o.out_z = r.pos_z;
		end else begin
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++) begin
					e = longint'($signed(rot[i][16*j +: 16]));
					acc += e * p[j];
				end
				p2[i] = rnd14(acc) - sh[i];
			end
			o.out_x = 32'(clamp(p2[0] - div_near(p2[2] * d[0], d[2]), 32, ov));
			o.out_y = 32'(clamp(p2[1] - div_near(p2[2] * d[1], d[2]), 32, ov));
			o.out_z = '0;
		end
		o.overflow = ov;
		return o;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= AW'(idx) << 3;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ROT0: rot[0] = val[47:0];
			REG_ROT1: rot[1] = val[47:0];
			REG_ROT2: rot[2] = val[47:0];
			REG_SHXY: shift_xy_q = val;
			REG_SHZ: shift_z_q = val[31:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (ray_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_ray(in_beat_t r);
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		ray_q.push_back(transfer_ray(r));
	endtask

	task automatic stop_send();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rnd_dir();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'($urandom_range(64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rnd_pos();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed(16'($urandom))) <<< 8;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_beat_t rnd_ray();
		in_beat_t r;
		r.pos_x = rnd_pos();
		r.pos_y = rnd_pos();
		r.pos_z = rnd_pos();
		r.dir_l = rnd_dir();
		r.dir_m = rnd_dir();
		r.dir_n = rnd_dir();
		return r;
	endfunction

	function automatic logic [47:0] rnd_row();
		if ($urandom_range(3) == 0)
			return 48'({$urandom, $urandom});
		return {16'($urandom_range(32767)) - 16'd16384,
			16'($urandom_range(32767)) - 16'd16384,
			16'($urandom_range(32767)) - 16'd16384};
	endfunction

	typedef struct {
		in_beat_t ray;
		bit known;
		out_beat_t res;
	} ray_row_t;

	ray_row_t dir_table[$];

	task automatic load_table();
		ray_row_t t;
		t = '{ray: '0, known: 1, res: '0};
		t.res.parallel = 1'b1;
		dir_table.push_back(t);
		t.ray = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h4000, 16'h0, 16'h0};
		t.res = '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h4000, 16'h0, 16'h0,
			1'b1, 1'b0};
		dir_table.push_back(t);
		t.ray = '{32'h0001_0000, 32'h0002_0000, 32'h0, 16'h0, 16'h0, 16'h4000};
		t.res = '{32'h0001_0000, 32'h0002_0000, 32'h0, 16'h0, 16'h0, 16'h4000,
			1'b0, 1'b0};
		dir_table.push_back(t);
		t.known = 0;
		t.ray = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h7fff, 16'h8000, 16'h0001};
		dir_table.push_back(t);
		t.ray = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'h8000, 16'h7fff, 16'hffff};
		dir_table.push_back(t);
		t.ray = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff};
		dir_table.push_back(t);
		t.ray = '{32'h0001_0000, 32'h0, 32'h0002_0000, 16'h2000, 16'h2000, 16'h4000};
		dir_table.push_back(t);
		t.ray = '{32'h0, 32'h0, 32'h0000_8000, 16'h0003, 16'h0, 16'h0002};
		dir_table.push_back(t);
	endtask

	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (80) @(posedge clk);
		hold_on <= 1'b0;
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (out_valid && !out_stall) begin
			if (ray_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected beat %p", out_data);
			end else begin
				want = ray_q.pop_front();
				if (out_data !== want) begin
					errors++;
					if (errors <= 10) $display("want %p got %p", want, out_data);
				end
			end
		end
		if (hold_on) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= recv_idle != 0 && $urandom_range(99) < recv_idle;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("ray_plane_transfer_unit: mismatch");
			$finish;
		end
	end

	initial begin
		ray_row_t row;
		in_beat_t r;
		rot[0] = ROT0_RST;
		rot[1] = ROT1_RST;
		rot[2] = ROT2_RST;
		shift_xy_q = '0;
		shift_z_q = '0;
		load_table();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_table[k]) begin
			row = dir_table[k];
			send_ray(row.ray);
			if (row.known) begin
				ray_q.pop_back();
				ray_q.push_back(row.res);
			end
		end
		stop_send();
		drain();
		write_reg(REG_SHXY, 64'h8000_0000_7fff_ffff);
		write_reg(REG_SHZ, 64'h8000_0000);
		write_reg(REG_ROT0, 64'h0000_8000_8000_8000);
		write_reg(REG_ROT1, 64'h0000_7fff_7fff_7fff);
		write_reg(REG_ROT2, 64'h0000_7fff_8000_7fff);
		for (int k = 0; k < 10; k++) send_ray(rnd_ray());
		stop_send();
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle = 69;
				recv_idle = 31;
			end
			if (ph >= 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_reg(REG_ROT0, 64'(rnd_row()));
			write_reg(REG_ROT1, 64'(rnd_row()));
			write_reg(REG_ROT2, 64'(rnd_row()));
			write_reg(REG_SHXY, {$urandom, $urandom});
			write_reg(REG_SHZ, 64'($urandom));
			if (ph == 4) hold_go = 1'b1;
			for (int k = 0; k < 200; k++) begin
				r = rnd_ray();
				send_ray(r);
			end
			stop_send();
			drain();
		end
		write_reg(REG_ROT0, 64'(ROT0_RST));
		write_reg(REG_ROT1, 64'(ROT1_RST));
		write_reg(REG_ROT2, 64'(ROT2_RST));
		write_reg(REG_SHXY, '0);
		write_reg(REG_SHZ, '0);
		for (int k = 0; k < 20; k++) send_ray(rnd_ray());
		stop_send();
		drain();
		if (errors == 0 && ray_q.size() == 0)
			$display("ray_plane_transfer_unit: match");
		else
			$display("ray_plane_transfer_unit: mismatch");
		$finish;
	end
endmodule
